[hdl/b2b_pkg.sv]
`timescale 1ns / 1ps
package b2b_pkg;

    localparam int unsigned WORDS_PER_BLOCK = 16;
    localparam int unsigned ROUNDS          = 12;
    localparam logic [63:0] ALL_ONES        = 64'hFFFFFFFFFFFFFFFF;

    // front to back queue entry
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } b2b_item_t;

    typedef enum logic [2:0] {
        ST_TAKE,
        ST_COMP,
        ST_FIN,
        ST_EMIT
    } b2b_state_t;

    function automatic logic [63:0] b2b_iv(input logic [2:0] i);
        logic [63:0] r;
        unique case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    // message schedule, row = round mod 10, column = position
    function automatic logic [3:0] b2b_sigma(input logic [3:0] r, input logic [3:0] p);
        logic [63:0] row;
        unique case (r)
            4'd0: row = 64'hfedcba9876543210;
            4'd1: row = 64'h357b20c16df984ae;
            4'd2: row = 64'h491763eadf250c8b;
            4'd3: row = 64'h8f04a562ebcd1397;
            4'd4: row = 64'hd386cb1efa427509;
            4'd5: row = 64'h91ef57d438b0a6c2;
            4'd6: row = 64'hb8293670a4def15c;
            4'd7: row = 64'ha2684f05931ce7bd;
            4'd8: row = 64'h5a417d2c803b9ef6;
            default: row = 64'h0dc3e9bf5167482a;
        endcase
        return row[p*4 +: 4];
    endfunction

    function automatic logic [6:0] b2b_dlen(input logic [6:0] d);
        logic [6:0] r;
        if (d == 7'd0) r = 7'd1;
        else if (d > 7'd64) r = 7'd64;
        else r = d;
        return r;
    endfunction

    function automatic logic [63:0] b2b_param(input logic [6:0] d, input logic [6:0] k);
        logic [6:0] kl;
        kl = (k > 7'd64) ? 7'd64 : k;
        return {32'd0, 8'd1, 8'd1, 1'b0, kl, 1'b0, b2b_dlen(d)};
    endfunction

    function automatic logic [63:0] b2b_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(n)) m[i*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

[hdl/b2b_front.sv]
`timescale 1ns / 1ps
module b2b_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_word,
    input  logic [3:0]        s_nbytes,
    input  logic              s_last,
    output logic              q_valid,
    input  logic              q_ready,
    output b2b_pkg::b2b_item_t q_item
);
    import b2b_pkg::*;

    // two-entry queue; items are saturated, masked and empties without last dropped here
    b2b_item_t  mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [3:0] nb;
    logic       push, pop, keep;

    assign nb       = (s_nbytes > 4'd8) ? 4'd8 : s_nbytes;
    assign keep     = (nb != 4'd0) || s_last;
    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= '{word: s_word & b2b_mask(nb), nbytes: nb, last: s_last};
        end
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_under: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count slip");
endmodule

[hdl/b2b_back.sv]
`timescale 1ns / 1ps
module b2b_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  b2b_pkg::b2b_item_t q_item,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_idx,
    input  logic               cfg_hit,
    input  logic [6:0]         cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_word,
    output logic [2:0]         m_index,
    output logic               m_lastw
);
    import b2b_pkg::*;

    b2b_state_t  st_reg, st_next;
    logic [63:0] h_reg [8];
    logic [63:0] m_reg [16];
    logic [63:0] v_reg [16];
    logic [127:0] t_reg;
    logic [4:0]  wib_reg;
    logic [6:0]  dl_reg, kl_reg;
    logic [3:0]  rnd_reg;       // round 0..11
    logic [2:0]  g_reg;         // G step within round, 0..7
    logic        fin_reg;
    logic [2:0]  ow_reg;
    logic [2:0]  nw;
    logic [6:0]  dlc;

    assign dlc = b2b_dlen(dl_reg);
    assign nw  = 3'((dlc - 7'd1) >> 3);

    // one G function per cycle on the working vector
    logic [3:0]  ia, ib, ic, id;
    logic [3:0]  rmod;
    logic [63:0] x, y, a1, d1, c1, b1, a2, d2, c2, b2;
    always_comb begin
        unique case (g_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        rmod = (rnd_reg >= 4'd10) ? rnd_reg - 4'd10 : rnd_reg;
        x  = m_reg[b2b_sigma(rmod, {g_reg, 1'b0})];
        y  = m_reg[b2b_sigma(rmod, {g_reg, 1'b1})];
        a1 = v_reg[ia] + v_reg[ib] + x;
        d1 = v_reg[id] ^ a1; d1 = {d1[31:0], d1[63:32]};
        c1 = v_reg[ic] + d1;
        b1 = v_reg[ib] ^ c1; b1 = {b1[23:0], b1[63:24]};
        a2 = a1 + b1 + y;
        d2 = d1 ^ a2; d2 = {d2[15:0], d2[63:16]};
        c2 = c1 + d2;
        b2 = b1 ^ c2; b2 = {b2[62:0], b2[63]};
    end

    logic take, start, fin_now;
    // full held block is compressed before new data goes in; the waiting
    // beat stays in the queue until the block has been folded
    assign start    = q_valid && (st_reg == ST_TAKE) && q_item.nbytes != 4'd0
                      && wib_reg == 5'(WORDS_PER_BLOCK);
    assign q_ready  = (st_reg == ST_TAKE) && !start;
    assign take     = q_valid && q_ready;
    assign m_tvalid = (st_reg == ST_EMIT);
    assign m_index  = ow_reg;
    assign m_lastw  = (ow_reg == nw);
    always_comb begin
        m_word = h_reg[ow_reg];
        if (ow_reg == nw && dlc[2:0] != 3'd0) m_word = m_word & b2b_mask({1'b0, dlc[2:0]});
    end

    always_comb begin
        st_next = st_reg;
        fin_now = 1'b0;
        unique case (st_reg)
            ST_TAKE: begin
                if (start) st_next = ST_COMP;
                else if (take && q_item.last) st_next = ST_COMP;
            end
            ST_COMP: if (rnd_reg == 4'(ROUNDS - 1) && g_reg == 3'd7) st_next = ST_FIN;
            ST_FIN: begin
                fin_now = 1'b1;
                if (fin_reg) st_next = ST_EMIT;
                else st_next = ST_TAKE;
            end
            ST_EMIT: if (m_tready && m_lastw) st_next = ST_TAKE;
            default: st_next = ST_TAKE;
        endcase
    end

    logic [127:0] t_new;
    logic idle_empty;
    assign t_new      = t_reg + {124'd0, q_item.nbytes};
    assign idle_empty = (t_reg == '0) && (wib_reg == 5'd0);

    always_ff @(posedge aclk) begin
        // store the taken word and zero the tail of a final block
        if (take) begin
            if (q_item.nbytes != 4'd0) m_reg[wib_reg[3:0]] <= q_item.word;
            if (q_item.last) begin
                for (int k = 0; k < 16; k++) begin
                    if (k >= int'(wib_reg) + ((q_item.nbytes != 4'd0) ? 1 : 0))
                        m_reg[k] <= '0;
                end
            end
        end
        if (st_next == ST_COMP && st_reg == ST_TAKE) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            for (int i = 0; i < 4; i++) v_reg[i+8] <= b2b_iv(3'(i));
            v_reg[12] <= b2b_iv(3'd4) ^ ((start || q_item.nbytes == 4'd0) ? t_reg[63:0]
                                                                         : t_new[63:0]);
            v_reg[13] <= b2b_iv(3'd5) ^ ((start || q_item.nbytes == 4'd0) ? t_reg[127:64]
                                                                         : t_new[127:64]);
            v_reg[14] <= b2b_iv(3'd6) ^ (start ? 64'd0 : ALL_ONES);
            v_reg[15] <= b2b_iv(3'd7);
        end
        if (st_reg == ST_COMP) begin
            v_reg[ia] <= a2; v_reg[ib] <= b2; v_reg[ic] <= c2; v_reg[id] <= d2;
        end
        if (st_reg == ST_FIN) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i+8];
        end
        if (!aresetn) begin
            st_reg <= ST_TAKE; rnd_reg <= '0; g_reg <= '0; fin_reg <= 1'b0;
            ow_reg <= '0; wib_reg <= '0; t_reg <= '0;
            dl_reg <= 7'd64; kl_reg <= 7'd0;
            for (int i = 1; i < 8; i++) h_reg[i] <= b2b_iv(3'(i));
            h_reg[0] <= b2b_iv(3'd0) ^ b2b_param(7'd64, 7'd0);
        end else begin
            st_reg <= st_next;
            if (start) begin
                fin_reg <= 1'b0;
                wib_reg <= 5'd0;
            end else if (take) begin
                fin_reg <= q_item.last;
                if (q_item.nbytes != 4'd0) begin
                    wib_reg <= wib_reg + 5'd1;
                    t_reg   <= t_new;
                end
            end
            if (st_reg == ST_COMP) begin
                g_reg <= g_reg + 3'd1;
                if (g_reg == 3'd7) rnd_reg <= rnd_reg + 4'd1;
            end else begin
                g_reg <= '0; rnd_reg <= '0;
            end
            if (st_reg == ST_EMIT && m_tready) ow_reg <= m_lastw ? 3'd0 : ow_reg + 3'd1;
            if (st_reg == ST_EMIT && m_tready && m_lastw) begin
                t_reg <= '0; wib_reg <= '0;
                for (int i = 1; i < 8; i++) h_reg[i] <= b2b_iv(3'(i));
                h_reg[0] <= b2b_iv(3'd0) ^ b2b_param(dl_reg, kl_reg);
            end
            if (cfg_we && cfg_hit) begin
                if (cfg_idx == 1'b0) dl_reg <= cfg_data; else kl_reg <= cfg_data;
                if (idle_empty && st_reg == ST_TAKE)
                    h_reg[0] <= b2b_iv(3'd0) ^ ((cfg_idx == 1'b0) ? b2b_param(cfg_data, kl_reg)
                                                                  : b2b_param(dl_reg, cfg_data));
            end
        end
    end

    a_take_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> st_reg == ST_TAKE) else $error("take while busy");
    a_wib: assert property (@(posedge aclk) disable iff (!aresetn)
        wib_reg <= 5'd16) else $error("block overfill");
    a_fin_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_FIN && fin_reg |=> m_tvalid) else $error("no digest after final");
    a_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(st_reg == ST_FIN) |-> $past(rnd_reg) == 4'(ROUNDS - 1)) else $error("rounds");
endmodule

[hdl/blake2b_hash_engine_core.sv]
// BLAKE2b hash engine, keyed or unkeyed, digest 1..64 bytes.
// Input stream s_*: one beat per 64-bit little-endian message word;
//   s_tuser holds valid_bytes (0..8, above 8 treated as 8), s_tlast marks
//   the message's final word. Empty beats without tlast are dropped.
// Output stream m_*: after a final word, ceil(digest_length/8) beats of
//   digest words; m_tuser holds word_index, m_tlast marks the final word.
// Config: cfg_we/cfg_index/cfg_wdata; index 0 digest_length, 1 key_length.
//   Write only while idle. A keyed hash sends the zero-padded key block first.
// Throughput: words are taken at one per cycle into a block while no block is
//   being compressed; a full block is compressed when the next data word arrives,
//   on the single G-function unit (8 G steps x 12 rounds) and then folded.
// From the last word, the final block is compressed and folded before the first
//   digest beat; a last word that meets a full held block waits for that block first.
// Reset (aresetn low, synchronous) clears the queue and loads the chain
//   value for digest length 64, key length 0.
// A stalled receiver holds the current digest beat; a two-entry input queue
//   keeps accepting until full.
`timescale 1ns / 1ps
module blake2b_hash_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // message_word
    input  logic [3:0]  s_tuser,   // valid_bytes
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);
    import b2b_pkg::*;

    logic      q_valid, q_ready;
    b2b_item_t q_item;

    b2b_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_word(s_tdata), .s_nbytes(s_tuser), .s_last(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    b2b_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_hit(1'b1), .cfg_data(cfg_wdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_word(m_tdata), .m_index(m_tuser), .m_lastw(m_tlast)
    );
endmodule
